@@ sv/lfpd_pkg.sv @@
// Shared types and constants for the line follower PD controller.
// Holds the transaction structs, codes, reset values and controller/datapath links.
// No dependencies.
`default_nettype none

package lfpd_pkg;

	// Sizes fixed by the interface
	localparam int LFPD_SENSOR_INPUTS = 4;
	localparam int LFPD_CFG_INDEX_W   = 3;
	localparam int LFPD_CFG_DATA_W    = 32;

	// Default module parameters
	localparam int LFPD_SENSOR_COUNT        = 4;
	localparam int LFPD_MARKER_MIN_BLACK    = 3;
	localparam int LFPD_MARKER_STABLE_TICKS = 20;

	// Reciprocal of 6 for the averaging step: floor(n/3/2) = (n * RECIP) >> SHIFT, n < 2^15
	localparam logic [15:0] LFPD_DIV6_RECIP = 16'd43691;
	localparam int          LFPD_DIV6_SHIFT = 18;

	// Register reset values
	localparam logic signed [15:0] RST_GAIN_PROP    = 16'sd256;
	localparam logic signed [15:0] RST_GAIN_DERIV   = 16'sd0;
	localparam logic signed [15:0] RST_CRUISE_SPEED = 16'sd0;
	localparam logic [8:0]         RST_CORNER_SCALE = 9'd128;
	localparam logic [14:0]        RST_SHARP_ERROR  = 15'd512;
	localparam logic [31:0]        RST_WEIGHTS      = 32'hD0F0_1030;
	localparam logic [15:0]        RST_LEAVE_CLEAR  = 16'd100;
	localparam logic [31:0]        RST_MIN_RUN      = 32'd2000;

	// Configuration register indexes
	typedef enum logic [LFPD_CFG_INDEX_W-1:0] {
		REG_GAIN_PROP,
		REG_GAIN_DERIV,
		REG_CRUISE_SPEED,
		REG_CORNER_SCALE,
		REG_SHARP_ERROR,
		REG_SENSOR_WEIGHTS,
		REG_LEAVE_CLEAR_TICKS,
		REG_MIN_RUN_TICKS
	} reg_index_t;

	// Command codes of an input transaction (the fourth code is ignored)
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_ABORT = 2'd2
	} opcode_t;

	// Run phase as reported on the output
	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_LEAVE  = 2'd1,
		PH_RUN    = 2'd2,
		PH_FINISH = 2'd3
	} run_phase_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_FIN
	} ctrl_state_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [3:0] sensor_bits;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] left_speed;
		logic signed [15:0] right_speed;
		logic [1:0]         run_phase;
		logic [31:0]        elapsed_ticks;
		logic signed [15:0] line_error;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic div_en;
		logic mul_en;
		logic commit;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic tick_active;
	} dp_status_t;

endpackage

`default_nettype wire

@@ sv/line_follower_pd_controller_unit.sv @@
// Top level of the line follower PD controller.
// Joins the sequencer (lfpd_ctrl) and the datapath (lfpd_datapath); depends on lfpd_pkg.
`default_nettype none

// One transaction at a time. A tick while leaving start or running passes through
// sum and count, averaging by the black-sensor count, the gain and base products,
// then rounding, saturation and the phase update; start, abort, ignored codes and
// ticks while idle or finished skip the multiply step. The input is stalled from
// acceptance until the result is written into the output register; a result held
// there by out_stall delays that write, so the next transaction may be accepted
// while one still waits.
// Configuration writes take effect at once and belong between transactions.
module line_follower_pd_controller_unit #(
	parameter int SENSOR_COUNT        = lfpd_pkg::LFPD_SENSOR_COUNT,
	parameter int MARKER_MIN_BLACK    = lfpd_pkg::LFPD_MARKER_MIN_BLACK,
	parameter int MARKER_STABLE_TICKS = lfpd_pkg::LFPD_MARKER_STABLE_TICKS
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_write,
	input  wire logic [lfpd_pkg::LFPD_CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [lfpd_pkg::LFPD_CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  lfpd_pkg::in_item_t                          in_data,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output lfpd_pkg::out_item_t                         out_data
);
	import lfpd_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	lfpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	lfpd_datapath #(
		.SENSOR_COUNT        (SENSOR_COUNT),
		.MARKER_MIN_BLACK    (MARKER_MIN_BLACK),
		.MARKER_STABLE_TICKS (MARKER_STABLE_TICKS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

	// one transaction in flight: input stalls right after acceptance
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while a transaction is in progress");

	// wheels stopped whenever idle or finished
	a_stopped_speeds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.run_phase == PH_IDLE || out_data.run_phase == PH_FINISH)
		|-> out_data.left_speed == 16'sd0 && out_data.right_speed == 16'sd0)
		else $error("non-zero speed reported while stopped");

	// elapsed time is cleared whenever the run is idle
	a_idle_elapsed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.run_phase == PH_IDLE |-> out_data.elapsed_ticks == 32'd0)
		else $error("elapsed ticks not cleared in idle");

endmodule

`default_nettype wire

@@ sv/lfpd_ctrl.sv @@
// Sequencer for the line follower PD controller.
// Steps one transaction through sum, average, multiply (active ticks only) and commit.
// Owns the output valid. Depends on lfpd_pkg.
`default_nettype none

module lfpd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  lfpd_pkg::dp_status_t   status,
	output lfpd_pkg::ctrl_cmd_t    cmd
);
	import lfpd_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;

	// output register can take a new result
	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_DIV;
			ST_DIV:  state_d = status.tick_active ? ST_MUL : ST_FIN;
			ST_MUL:  state_d = ST_FIN;
			ST_FIN:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_DIV:  cmd.div_en = 1'b1;
			ST_MUL:  cmd.mul_en = 1'b1;
			ST_FIN:  cmd.commit = out_free;
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ sv/lfpd_datapath.sv @@
// Datapath of the line follower PD controller: registers, weighted error,
// PD products, saturation and run-phase bookkeeping.
// Depends on lfpd_pkg; driven by lfpd_ctrl.
`default_nettype none

module lfpd_datapath #(
	parameter int SENSOR_COUNT        = lfpd_pkg::LFPD_SENSOR_COUNT,
	parameter int MARKER_MIN_BLACK    = lfpd_pkg::LFPD_MARKER_MIN_BLACK,
	parameter int MARKER_STABLE_TICKS = lfpd_pkg::LFPD_MARKER_STABLE_TICKS
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_write,
	input  wire logic [lfpd_pkg::LFPD_CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [lfpd_pkg::LFPD_CFG_DATA_W-1:0]   cfg_data,
	input  lfpd_pkg::in_item_t                          in_data,
	input  lfpd_pkg::ctrl_cmd_t                         cmd,
	output lfpd_pkg::dp_status_t                        status,
	output lfpd_pkg::out_item_t                         out_data
);
	import lfpd_pkg::*;

	// configuration
	logic signed [15:0] gain_prop_q, gain_deriv_q, cruise_speed_q;
	logic [8:0]         corner_scale_q;
	logic [14:0]        sharp_error_q;
	logic [31:0]        weights_q;
	logic [15:0]        leave_clear_q;
	logic [31:0]        min_run_q;

	// run state
	run_phase_t         phase_q;
	logic signed [15:0] held_err_q, prev_err_q;
	logic [15:0]        clear_q;
	logic [7:0]         stable_q;
	logic [31:0]        elapsed_q;

	// stage registers
	logic [1:0]         op_s1;
	logic signed [10:0] sum_s1;
	logic [2:0]         cnt_s1;
	logic signed [15:0] err_s2;
	logic               marker_s2;
	logic signed [31:0] prop_s3;
	logic signed [32:0] der_s3;
	logic signed [25:0] base_s3;
	logic               sharp_s3;
	out_item_t          out_q;

	function automatic logic signed [15:0] sat16(input logic signed [26:0] x);
		if (x > 27'sd32767)
			return 16'sh7FFF;
		else if (x < -27'sd32768)
			return 16'sh8000;
		else
			return x[15:0];
	endfunction

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q    <= RST_GAIN_PROP;
			gain_deriv_q   <= RST_GAIN_DERIV;
			cruise_speed_q <= RST_CRUISE_SPEED;
			corner_scale_q <= RST_CORNER_SCALE;
			sharp_error_q  <= RST_SHARP_ERROR;
			weights_q      <= RST_WEIGHTS;
			leave_clear_q  <= RST_LEAVE_CLEAR;
			min_run_q      <= RST_MIN_RUN;
		end else if (cfg_write) begin
			unique case (reg_index_t'(cfg_index))
				REG_GAIN_PROP:         gain_prop_q    <= cfg_data[15:0];
				REG_GAIN_DERIV:        gain_deriv_q   <= cfg_data[15:0];
				REG_CRUISE_SPEED:      cruise_speed_q <= cfg_data[15:0];
				REG_CORNER_SCALE:      corner_scale_q <= cfg_data[8:0];
				REG_SHARP_ERROR:       sharp_error_q  <= cfg_data[14:0];
				REG_SENSOR_WEIGHTS:    weights_q      <= cfg_data;
				REG_LEAVE_CLEAR_TICKS: leave_clear_q  <= cfg_data[15:0];
				REG_MIN_RUN_TICKS:     min_run_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: weighted sum and count of black sensors
	logic signed [10:0] sum_c;
	logic [2:0]         cnt_c;

	always_comb begin
		sum_c = '0;
		cnt_c = '0;
		for (int i = 0; i < LFPD_SENSOR_INPUTS; i++) begin
			if (i < SENSOR_COUNT && in_data.sensor_bits[i]) begin
				sum_c = sum_c + 11'(signed'(weights_q[8*i +: 8]));
				cnt_c = cnt_c + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_s1  <= in_data.opcode;
			sum_s1 <= sum_c;
			cnt_s1 <= cnt_c;
		end
	end

	// stage 2: rounded average, ties away from zero; held error when no sensor is black
	logic [9:0]         abs_sum;
	logic [13:0]        a_mag;
	logic [14:0]        n3;
	logic [30:0]        prod3;
	logic [13:0]        q_mag;
	logic signed [15:0] err_c;

	assign abs_sum = sum_s1[10] ? 10'(-sum_s1) : 10'(sum_s1);
	assign a_mag   = {abs_sum, 4'b0000};
	assign n3      = {a_mag, 1'b0} + 15'd3;
	assign prod3   = 31'(n3) * 31'(LFPD_DIV6_RECIP);

	always_comb begin
		case (cnt_s1)
			3'd2:    q_mag = 14'((15'(a_mag) + 15'd1) >> 1);
			3'd3:    q_mag = 14'(prod3 >> LFPD_DIV6_SHIFT);
			3'd4:    q_mag = 14'((15'(a_mag) + 15'd2) >> 2);
			default: q_mag = a_mag;
		endcase
		if (cnt_s1 == 3'd0)
			err_c = held_err_q;
		else if (sum_s1[10])
			err_c = -signed'(16'(q_mag));
		else
			err_c = signed'(16'(q_mag));
	end

	always_ff @(posedge clk) begin
		if (cmd.div_en) begin
			err_s2    <= err_c;
			marker_s2 <= 4'(cnt_s1) >= 4'(MARKER_MIN_BLACK);
		end
	end

	// stage 3: gain and base products, sharp-error check
	logic signed [16:0] diff_c;
	logic [15:0]        abs_err;

	assign diff_c  = 17'(err_s2) - 17'(prev_err_q);
	assign abs_err = err_s2[15] ? 16'(-err_s2) : 16'(err_s2);

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prop_s3  <= 32'(gain_prop_q) * 32'(err_s2);
			der_s3   <= 33'(gain_deriv_q) * 33'(diff_c);
			base_s3  <= 26'(cruise_speed_q) * 26'(signed'({1'b0, corner_scale_q}));
			sharp_s3 <= abs_err > {1'b0, sharp_error_q};
		end
	end

	// stage 4: correction, wheel speeds
	logic signed [33:0] psum_c;
	logic signed [25:0] corr_c;
	logic signed [25:0] base_rnd;
	logic signed [15:0] base_sel;
	logic signed [15:0] left_c, right_c;

	assign psum_c   = 34'(prop_s3) + 34'(der_s3) + 34'sd128;
	assign corr_c   = psum_c[33:8];
	assign base_rnd = base_s3 + 26'sd128;
	assign base_sel = (marker_s2 || sharp_s3) ? sat16(27'(signed'(base_rnd[25:8])))
	                                           : cruise_speed_q;
	assign left_c   = sat16(27'(base_sel) + 27'(corr_c));
	assign right_c  = sat16(27'(base_sel) - 27'(corr_c));

	// run-phase bookkeeping
	logic        active_c;
	logic [31:0] elapsed_inc;
	logic [15:0] clear_inc;
	logic [7:0]  stable_inc;

	run_phase_t         phase_d;
	logic signed [15:0] held_d, prev_d;
	logic [15:0]        clear_d;
	logic [7:0]         stable_d;
	logic [31:0]        elapsed_d;
	logic signed [15:0] left_d, right_d;

	assign active_c    = (op_s1 == OP_TICK) && (phase_q == PH_LEAVE || phase_q == PH_RUN);
	assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 32'd1;
	assign clear_inc   = (&clear_q) ? clear_q : clear_q + 16'd1;
	assign stable_inc  = (&stable_q) ? stable_q : stable_q + 8'd1;

	always_comb begin
		phase_d   = phase_q;
		held_d    = held_err_q;
		prev_d    = prev_err_q;
		clear_d   = clear_q;
		stable_d  = stable_q;
		elapsed_d = elapsed_q;
		left_d    = '0;
		right_d   = '0;
		unique case (op_s1)
			OP_START: begin
				phase_d   = PH_LEAVE;
				held_d    = '0;
				prev_d    = '0;
				clear_d   = '0;
				stable_d  = '0;
				elapsed_d = '0;
			end
			OP_ABORT: begin
				phase_d   = PH_IDLE;
				elapsed_d = '0;
			end
			OP_TICK: begin
				if (active_c) begin
					elapsed_d = elapsed_inc;
					held_d    = err_s2;
					prev_d    = err_s2;
					left_d    = left_c;
					right_d   = right_c;
					if (phase_q == PH_LEAVE) begin
						clear_d = marker_s2 ? 16'd0 : clear_inc;
						if (clear_d >= leave_clear_q)
							phase_d = PH_RUN;
					end else if (marker_s2 && elapsed_inc > min_run_q) begin
						stable_d = stable_inc;
						if (stable_inc >= 8'(MARKER_STABLE_TICKS)) begin
							phase_d = PH_FINISH;
							left_d  = '0;
							right_d = '0;
						end
					end else begin
						stable_d = '0;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			held_err_q <= '0;
			prev_err_q <= '0;
			clear_q    <= '0;
			stable_q   <= '0;
			elapsed_q  <= '0;
		end else if (cmd.commit) begin
			phase_q    <= phase_d;
			held_err_q <= held_d;
			prev_err_q <= prev_d;
			clear_q    <= clear_d;
			stable_q   <= stable_d;
			elapsed_q  <= elapsed_d;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q.left_speed    <= left_d;
			out_q.right_speed   <= right_d;
			out_q.run_phase     <= phase_d;
			out_q.elapsed_ticks <= elapsed_d;
			out_q.line_error    <= held_d;
		end
	end

	assign out_data           = out_q;
	assign status.tick_active = active_c;

endmodule

`default_nettype wire
